### src/ftod_pkg.sv
package ftod_pkg;

  // Day counter width; the days field reports its low 16 bits
  localparam int DAY_BITS = 16;
  localparam int ACC_W    = 32;
  localparam int DAYS_W   = 16;
  localparam int SEC_W    = 6;
  localparam int MIN_W    = 6;
  localparam int HOUR_W   = 5;

  localparam logic [ACC_W-1:0]  TICK_STEP = 32'h0001_0000;
  localparam logic [SEC_W-1:0]  SEC_LAST  = 6'd59;
  localparam logic [MIN_W-1:0]  MIN_LAST  = 6'd59;
  localparam logic [HOUR_W-1:0] HOUR_LAST = 5'd23;

  typedef struct packed {
    logic              half_step;
    logic              half_bit;
    logic [SEC_W-1:0]  seconds;
    logic [MIN_W-1:0]  minutes;
    logic [HOUR_W-1:0] hours;
    logic [DAYS_W-1:0] days;
  } ftod_word_t;

  // Zero-extend, then keep the low bits of the day count
  function automatic logic [DAYS_W-1:0] day_to_out(input logic [DAY_BITS-1:0] d);
    logic [DAY_BITS+DAYS_W-1:0] ext;
    ext = {{DAYS_W{1'b0}}, d};
    return ext[DAYS_W-1:0];
  endfunction

endpackage

### src/ftod_phase.sv
module ftod_phase (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [ftod_pkg::ACC_W-1:0] cfg_wr_data,
  input  logic                      tick,
  output logic                      step
);

  logic [ftod_pkg::ACC_W-1:0] period_r;
  logic [ftod_pkg::ACC_W-1:0] acc_r;
  logic [ftod_pkg::ACC_W-1:0] acc_nxt;
  logic [ftod_pkg::ACC_W-1:0] acc_sum;
  logic                       over;

  // Add wraps modulo 2^32 before the compare
  assign acc_sum = acc_r + ftod_pkg::TICK_STEP;
  assign over    = acc_sum > period_r;
  assign step    = tick & over;

  always_comb begin
    acc_nxt = acc_r;
    if (tick) begin
      acc_nxt = over ? (acc_sum - period_r) : acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      acc_r    <= '0;
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      acc_r <= acc_nxt;
    end
  end

endmodule

### src/ftod_tod.sv
module ftod_tod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  logic                 step,
  output ftod_pkg::ftod_word_t word
);

  logic                               half_r, half_nxt;
  logic [ftod_pkg::SEC_W-1:0]         sec_r, sec_nxt;
  logic [ftod_pkg::MIN_W-1:0]         min_r, min_nxt;
  logic [ftod_pkg::HOUR_W-1:0]        hour_r, hour_nxt;
  logic [ftod_pkg::DAY_BITS-1:0]      day_r, day_nxt;
  logic                               c_sec, c_min, c_hour, c_day;

  // Carry chain: half wraps into seconds, seconds into minutes, and so on
  assign c_sec  = step & half_r;
  assign c_min  = c_sec & (sec_r == ftod_pkg::SEC_LAST);
  assign c_hour = c_min & (min_r == ftod_pkg::MIN_LAST);
  assign c_day  = c_hour & (hour_r == ftod_pkg::HOUR_LAST);

  always_comb begin
    half_nxt = half_r ^ step;
    sec_nxt  = sec_r;
    min_nxt  = min_r;
    hour_nxt = hour_r;
    day_nxt  = day_r;
    if (c_sec) begin
      sec_nxt = c_min ? '0 : sec_r + 1'b1;
    end
    if (c_min) begin
      min_nxt = c_hour ? '0 : min_r + 1'b1;
    end
    if (c_hour) begin
      hour_nxt = c_day ? '0 : hour_r + 1'b1;
    end
    if (c_day) begin
      day_nxt = day_r + 1'b1;
    end
  end

  assign word.half_step = step;
  assign word.half_bit  = half_nxt;
  assign word.seconds   = sec_nxt;
  assign word.minutes   = min_nxt;
  assign word.hours     = hour_nxt;
  assign word.days      = ftod_pkg::day_to_out(day_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
      sec_r  <= '0;
      min_r  <= '0;
      hour_r <= '0;
      day_r  <= '0;
    end else if (accept) begin
      half_r <= half_nxt;
      sec_r  <= sec_nxt;
      min_r  <= min_nxt;
      hour_r <= hour_nxt;
      day_r  <= day_nxt;
    end
  end

`ifndef SYNTH
  a_sec_range: assert property (@(posedge clk) disable iff (!rst_n)
    sec_r <= ftod_pkg::SEC_LAST)
    else $error("seconds out of range");
  a_min_range: assert property (@(posedge clk) disable iff (!rst_n)
    min_r <= ftod_pkg::MIN_LAST)
    else $error("minutes out of range");
  a_hour_roll: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && c_day) |=> (hour_r == '0 && min_r == '0 && sec_r == '0 && !half_r))
    else $error("day roll did not clear the time of day");
`endif

endmodule

### src/ftod_outq.sv
module ftod_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  ftod_pkg::ftod_word_t push_word,
  output logic                 full,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ftod_pkg::ftod_word_t out_word
);

  ftod_pkg::ftod_word_t mem_r [2];
  logic                 wr_ptr_r, rd_ptr_r;
  logic [1:0]           count_r, count_nxt;
  logic                 pop;

  assign full      = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign pop       = out_valid & ~out_stall;
  assign out_word  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("output queue overfilled");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with fill count");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 2'd1))
    else $error("push lost");
`endif

endmodule

### src/fractional_tick_time_of_day_clock_unit.sv
// Phase-accumulator time-of-day clock. Each word with in_advance set is one
// timer overflow: 65536 is added to a 32-bit accumulator (wrapping), and when
// the sum is strictly above the threshold on cfg_wr_data, the threshold is
// subtracted and the half-second bit toggles, carrying into seconds, minutes,
// hours and a 16-bit day count. A word with in_advance clear only reports the
// time. Every input word gives exactly one result word holding the time after
// any step. One word is accepted per cycle unless the two-word output queue
// is full, which needs a stalled output; the step is worked out in the accept
// cycle and the result word is registered into the queue and shown from there.
// Write the threshold only while the block is idle.
module fractional_tick_time_of_day_clock_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [ftod_pkg::ACC_W-1:0]  cfg_wr_data,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_advance,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_half_step,
  output logic                        out_half_bit,
  output logic [ftod_pkg::SEC_W-1:0]  out_seconds,
  output logic [ftod_pkg::MIN_W-1:0]  out_minutes,
  output logic [ftod_pkg::HOUR_W-1:0] out_hours,
  output logic [ftod_pkg::DAYS_W-1:0] out_days
);

  logic                 full;
  logic                 accept;
  logic                 step;
  ftod_pkg::ftod_word_t res_word;
  ftod_pkg::ftod_word_t q_word;

  // Hold input off only while the queue is full
  assign in_stall = full;
  assign accept   = in_valid & ~full;

  // Phase accumulator: advance on accepted ticks only
  ftod_phase u_phase (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick        (accept & in_advance),
    .step        (step)
  );

  // Time-of-day counters
  ftod_tod u_tod (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .step   (step),
    .word   (res_word)
  );

  // Result queue decouples the output stall from input acceptance
  ftod_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_word (res_word),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (q_word)
  );

  assign out_half_step = q_word.half_step;
  assign out_half_bit  = q_word.half_bit;
  assign out_seconds   = q_word.seconds;
  assign out_minutes   = q_word.minutes;
  assign out_hours     = q_word.hours;
  assign out_days      = q_word.days;

endmodule
